FILE: hw/rtl/scas_pkg.sv
// ----------------------------------------------------------------------------
// scas_pkg : shared types and constants for the set-associative cache model
// Field widths, configuration register indexes and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package scas_pkg;

  localparam int IDX_W      = 31;  // element index / block number
  localparam int GRAN_W     = 16;  // granule and divisor width
  localparam int CNT_W      = 32;  // hit / access counters, stride
  localparam int DIFF_W     = 33;  // signed index difference
  localparam int DIV_CNT_W  = 5;   // iteration counter of the divider
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRANULE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LRU_MODE = CFG_IDX_W'(1);

  typedef struct packed {
    logic              start;
    logic [IDX_W-1:0]  dividend;
    logic [GRAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, results valid from here on
  } div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/set_assoc_cache_hit_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_sim : set-associative cache hit model, LRU or FIFO
// Serial divide by granule, set lookup and way search, recency writeback.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------------
//  in      | in  | in_valid_i / in_stall_o   | element_index_i
//  out     | out | out_valid_o / out_stall_i | hit_o, hit_count_o, access_count_o,
//          |     |                           | max_stride_o
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A beat runs a divide by granule, then a modulo pass when the set count is not
//  a power of two, then the metadata read and a search over k ways (0..WAYS).
//  The shared bit-serial divider (31 steps a pass) serves both passes, and the tag
//  search compares one way per cycle through the single tag RAM read port.
//  After reset a clearing pass zeroes the set metadata RAM;
//  no beat is taken meanwhile, configuration writes are.
//  A finished result sits in the output register while the next beat is taken;
//  the writeback of that next beat waits while out_stall_i holds the result.
//
`default_nettype none

module set_assoc_cache_hit_sim #(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input beats
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [scas_pkg::IDX_W-1:0]      element_index_i,
  // result beats
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [scas_pkg::CNT_W-1:0]      hit_count_o,
  output logic [scas_pkg::CNT_W-1:0]      access_count_o,
  output logic [scas_pkg::CNT_W-1:0]      max_stride_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scas_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import scas_pkg::*;

  // geometry
  localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  RANK_W    = WAY_W;
  localparam int  FILL_W    = $clog2(WAYS + 1);
  localparam int  META_W    = FILL_W + WAYS * RANK_W;
  localparam int  META_AW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  TAG_DEPTH = SETS * (1 << WAY_W);
  localparam int  TAG_AW    = $clog2(TAG_DEPTH);
  localparam bit  SET_POW2  = (SETS > 1) && (SETS == (1 << $clog2(SETS)));

  localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(SETS - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WAYS);
  localparam logic [RANK_W-1:0] TAIL_RANK = RANK_W'(WAYS - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // metadata clearing pass
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;  // index / granule
  localparam logic [2:0] S_MOD   = 3'd3;  // block mod SETS
  localparam logic [2:0] S_MREQ  = 3'd4;  // metadata read issued
  localparam logic [2:0] S_MCAP  = 3'd5;  // metadata captured, first tag read
  localparam logic [2:0] S_TCMP  = 3'd6;  // one way compared per cycle
  localparam logic [2:0] S_WB    = 3'd7;  // recency writeback, result out

  typedef logic [WAYS-1:0][RANK_W-1:0] rank_vec_t;

  logic [2:0]         state_q, state_d;
  logic [SET_W-1:0]   clr_q;

  // configuration
  logic [GRAN_W-1:0]  granule_q;
  logic               lru_q;

  // per-item working registers
  logic [IDX_W-1:0]   block_q;
  logic [SET_W-1:0]   set_q;
  logic [FILL_W-1:0]  fill_q;
  rank_vec_t          rank_q;
  logic [WAY_W-1:0]   way_q;
  logic               hit_q;
  logic [WAY_W-1:0]   hit_way_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [CNT_W-1:0]   stride_q;

  // running state
  logic signed [DIFF_W-1:0] prev_q;
  logic [CNT_W-1:0]   hits_q;
  logic [CNT_W-1:0]   acc_q;
  logic [CNT_W-1:0]   max_q;
  logic               out_valid_q;
  logic               out_hit_q;

  // divider
  div_req_t           div_req;
  div_status_t        div_status;
  logic [IDX_W-1:0]   div_quo;
  logic [GRAN_W-1:0]  div_rem;

  // RAMs
  logic               meta_we;
  logic [META_W-1:0]  meta_wdata;
  logic [META_AW-1:0] meta_waddr;
  logic [META_W-1:0]  meta_rdata;
  logic               tag_we;
  logic [TAG_AW-1:0]  tag_waddr;
  logic [TAG_AW-1:0]  tag_raddr;
  logic [IDX_W-1:0]   tag_rdata;

  logic               in_take;
  logic               wb_fire;
  logic [FILL_W-1:0]  way_next;
  logic               tag_match;

  // writeback results
  rank_vec_t          rank_n;
  logic [FILL_W-1:0]  fill_n;
  logic [WAY_W-1:0]   tail_way;
  logic [WAY_W-1:0]   new_way;

  assign in_take   = in_valid_i && (state_q == S_IDLE);
  assign wb_fire   = (state_q == S_WB) && (!out_valid_q || !out_stall_i);
  assign way_next  = FILL_W'(way_q) + FILL_W'(1);
  assign tag_match = (tag_rdata == block_q);

  // --------------------------------------------------------------------------
  // shared divider: first pass by granule, optional second pass by SETS
  // --------------------------------------------------------------------------
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = element_index_i;
    div_req.divisor  = (granule_q == '0) ? GRAN_W'(1) : granule_q;
    if (in_take) begin
      div_req.start = 1'b1;
    end else if ((state_q == S_DIV) && div_status.done && !SET_POW2) begin
      div_req.start    = 1'b1;
      div_req.dividend = div_quo;
      div_req.divisor  = GRAN_W'(SETS);
    end
  end

  scas_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .status_o    (div_status),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LAST_SET) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_DIV;
      S_DIV: begin
        if (div_status.done) state_d = SET_POW2 ? S_MREQ : S_MOD;
      end
      S_MOD:   if (div_status.done) state_d = S_MREQ;
      S_MREQ:  state_d = S_MCAP;
      S_MCAP: begin
        state_d = (meta_rdata[FILL_W-1:0] == '0) ? S_WB : S_TCMP;
      end
      S_TCMP: begin
        if (tag_match || (way_next == fill_q)) state_d = S_WB;
      end
      S_WB:    if (wb_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      granule_q   <= GRAN_W'(1);
      lru_q       <= 1'b1;
      prev_q      <= '1;
      hits_q      <= '0;
      acc_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + SET_W'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GRANULE:  granule_q <= cfg_data_i;
          REG_LRU_MODE: lru_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_take) begin
        prev_q <= DIFF_W'(element_index_i);
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
        acc_q       <= (acc_q == '1) ? acc_q : acc_q + CNT_W'(1);
        if (hit_q && (hits_q != '1)) hits_q <= hits_q + CNT_W'(1);
        if (stride_q > max_q) max_q <= stride_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      diff_q <= $signed(DIFF_W'(element_index_i)) - prev_q;
    end
    if ((state_q == S_DIV) && div_status.done) begin
      block_q <= div_quo;
      set_q   <= SET_W'(div_quo);
    end
    if ((state_q == S_MOD) && div_status.done) begin
      set_q <= SET_W'(div_rem);
    end
    if (state_q == S_MREQ) begin
      stride_q <= diff_q[DIFF_W-1] ? CNT_W'(-diff_q) : CNT_W'(diff_q);
    end
    if (state_q == S_MCAP) begin
      fill_q <= meta_rdata[FILL_W-1:0];
      rank_q <= meta_rdata[META_W-1:FILL_W];
      way_q  <= '0;
      hit_q  <= 1'b0;
    end
    if (state_q == S_TCMP) begin
      if (tag_match) begin
        hit_q     <= 1'b1;
        hit_way_q <= way_q;
      end else begin
        way_q <= way_q + WAY_W'(1);
      end
    end
    if (wb_fire) begin
      out_hit_q <= hit_q;
    end
  end

  // --------------------------------------------------------------------------
  // recency update of the set
  // --------------------------------------------------------------------------
  always_comb begin
    rank_n   = rank_q;
    fill_n   = fill_q;
    tail_way = '0;
    new_way  = '0;
    tag_we   = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < fill_q) && (rank_q[w] == TAIL_RANK)) tail_way = WAY_W'(w);
    end
    if (hit_q) begin
      if (lru_q) begin
        for (int w = 0; w < WAYS; w++) begin
          if ((FILL_W'(w) < fill_q) && (rank_q[w] < rank_q[hit_way_q])) begin
            rank_n[w] = rank_q[w] + RANK_W'(1);
          end
        end
        rank_n[hit_way_q] = '0;
      end
    end else if (fill_q < FULL) begin
      // free way left: everyone ages, new block at the front
      for (int w = 0; w < WAYS; w++) begin
        if (FILL_W'(w) < fill_q) rank_n[w] = rank_q[w] + RANK_W'(1);
      end
      new_way         = WAY_W'(fill_q);
      rank_n[new_way] = '0;
      fill_n          = fill_q + FILL_W'(1);
      tag_we          = wb_fire;
    end else begin
      // set full: tail is replaced
      for (int w = 0; w < WAYS; w++) begin
        if (rank_q[w] < TAIL_RANK) rank_n[w] = rank_q[w] + RANK_W'(1);
      end
      new_way          = tail_way;
      rank_n[tail_way] = '0;
      tag_we           = wb_fire;
    end
  end

  // --------------------------------------------------------------------------
  // storage: set metadata (fill + ranks) and tags
  // --------------------------------------------------------------------------
  assign meta_we    = (state_q == S_CLEAR) || wb_fire;
  assign meta_waddr = (state_q == S_CLEAR) ? META_AW'(clr_q) : META_AW'(set_q);
  assign meta_wdata = (state_q == S_CLEAR) ? '0 : {rank_n, fill_n};

  scas_ram #(
    .WIDTH (META_W),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (META_AW'(set_q)),
    .rdata_o (meta_rdata)
  );

  // first way read in S_MCAP, then the way after the one being compared
  assign tag_raddr = (state_q == S_TCMP) ? TAG_AW'({set_q, way_q + WAY_W'(1)})
                                         : TAG_AW'({set_q, {WAY_W{1'b0}}});
  assign tag_waddr = TAG_AW'({set_q, new_way});

  scas_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (block_q),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // --------------------------------------------------------------------------
  // ports
  // --------------------------------------------------------------------------
  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign hit_count_o    = hits_q;
  assign access_count_o = acc_q;
  assign max_stride_o   = max_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_new_result_from_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_WB)
    else $error("result raised outside writeback");

  a_take_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DIV) && div_status.busy)
    else $error("accepted beat did not start the divider");

  a_hits_le_accesses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q <= acc_q)
    else $error("hit count above access count");

  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (fill_q <= FULL))
    else $error("set fill beyond way count");

  a_stride_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q <= 32'h8000_0000)
    else $error("stride beyond index range");

endmodule

`default_nettype wire

FILE: hw/rtl/scas_ram.sv
// ----------------------------------------------------------------------------
// scas_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scas_div.sv
// ----------------------------------------------------------------------------
// scas_div : shared restoring divider, one quotient bit per cycle
// 31-bit dividend by 16-bit divisor; quotient and remainder after 31 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module scas_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scas_pkg::div_req_t          req_i,
  output scas_pkg::div_status_t       status_o,
  output logic [scas_pkg::IDX_W-1:0]  quotient_o,
  output logic [scas_pkg::GRAN_W-1:0] remainder_o
);

  import scas_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(IDX_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0]     quo_q;
  logic [GRAN_W-1:0]    rem_q;
  logic [GRAN_W-1:0]    dvs_q;

  logic [GRAN_W:0]      trial;
  logic [GRAN_W:0]      diff;
  logic                 take;

  // shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[IDX_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[IDX_W-2:0], take};
      rem_q <= take ? diff[GRAN_W-1:0] : trial[GRAN_W-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

FILE: sim/set_assoc_cache_hit_sim_test.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_sim_test : self-checking bench for the cache hit model
// Drives element indices through a directed table and then randomised phases
// under several granule / replacement settings. Every result beat is compared
// with its typed table value or an in-bench predictor of the sets, ranks, counters and stride.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module set_assoc_cache_hit_sim_test;
  import scas_pkg::*;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int PLAN_LEN    = 27;
  localparam int PHASES      = 7;
  localparam int PHASE_BEATS = 120;
  localparam int POOL_LEN    = 10;

  // index outside the register map, a write to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(15);

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] stride;
  } cache_result_t;

  // one line of the directed table: a register write or an access
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [IDX_W-1:0]      index;
    bit                    typed;
    cache_result_t         want;
  } plan_row_t;

  // ports
  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [IDX_W-1:0]      element_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic                  hit_o;
  logic [CNT_W-1:0]      hit_count_o;
  logic [CNT_W-1:0]      access_count_o;
  logic [CNT_W-1:0]      max_stride_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  set_assoc_cache_hit_sim #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_index_i(element_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o),
    .max_stride_o   (max_stride_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the cache state, updated once per accepted beat
  // ---------------------------------------------------------------------------
  logic [GRAN_W-1:0] granule_q  = GRAN_W'(1);
  bit                lru_q      = 1'b1;
  logic [IDX_W-1:0]  tag_q  [SETS*WAYS];
  int unsigned       rank_q [SETS*WAYS] = '{default: 0};
  int unsigned       fill_q [SETS]      = '{default: 0};
  logic [CNT_W-1:0]  hits_q     = '0;
  logic [CNT_W-1:0]  accesses_q = '0;
  logic [CNT_W-1:0]  stride_q   = '0;
  longint            prev_q     = -1;   // first stride is index + 1

  cache_result_t     result_q [$];      // results still owed by the block
  int                errors = 0;

  // every valid way of the set ranked below limit drops one place
  function automatic void age_ranks(int unsigned base, int unsigned n, int unsigned limit);
    for (int w = 0; w < n; w++) begin
      if (rank_q[base+w] < limit) rank_q[base+w]++;
    end
  endfunction

  function automatic cache_result_t cache_access(logic [IDX_W-1:0] raw);
    int unsigned   divisor;
    int unsigned   blk;
    int unsigned   set_no;
    int unsigned   base;
    int unsigned   n_fill;
    int unsigned   way;
    int unsigned   tail;
    bit            found;
    longint        delta;
    cache_result_t r;
    divisor = (granule_q == '0) ? 1 : granule_q;  // zero granule acts as 1
    blk     = raw / divisor;
    set_no  = blk % SETS;
    base    = set_no * WAYS;
    n_fill  = fill_q[set_no];
    found   = 1'b0;
    way     = 0;
    tail    = 0;
    if (accesses_q != '1) accesses_q++;
    for (int w = 0; w < n_fill; w++) begin
      if (!found && tag_q[base+w] == IDX_W'(blk)) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      if (hits_q != '1) hits_q++;
      if (lru_q) begin
        age_ranks(base, n_fill, rank_q[base+way]);
        rank_q[base+way] = 0;
      end
    end else if (n_fill < WAYS) begin
      age_ranks(base, n_fill, WAYS);
      tag_q[base+n_fill]  = IDX_W'(blk);
      rank_q[base+n_fill] = 0;
      fill_q[set_no]      = n_fill + 1;
    end else begin
      // full set: the oldest way is replaced and becomes the newest
      for (int w = 0; w < n_fill; w++) begin
        if (rank_q[base+w] == WAYS - 1) tail = w;
      end
      age_ranks(base, n_fill, WAYS - 1);
      tag_q[base+tail]  = IDX_W'(blk);
      rank_q[base+tail] = 0;
    end
    delta = longint'(raw) - prev_q;
    if (delta < 0) delta = -delta;
    prev_q = longint'(raw);
    if (delta[CNT_W-1:0] > stride_q) stride_q = delta[CNT_W-1:0];
    r.hit      = found;
    r.hits     = hits_q;
    r.accesses = accesses_q;
    r.stride   = stride_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check each beat, stall on a pattern of its own
  // ---------------------------------------------------------------------------
  cache_result_t want_r;
  int unsigned   stall_mode = 0;
  int unsigned   stall_run  = 0;
  int unsigned   mode_left  = 0;

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        want_r = result_q.pop_front();
        check_field("hit", CNT_W'(want_r.hit), CNT_W'(hit_o));
        check_field("hit_count", want_r.hits, hit_count_o);
        check_field("access_count", want_r.accesses, access_count_o);
        check_field("max_stride", want_r.stride, max_stride_o);
      end
    end
    // modes: never stall, occasional short stalls, long heavy stalls
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    if (stall_run != 0) begin
      stall_run--;
    end else if (stall_mode == 1 && $urandom_range(0, 7) == 0) begin
      stall_run = $urandom_range(1, 4);
    end else if (stall_mode == 2 && $urandom_range(0, 2) == 0) begin
      stall_run = $urandom_range(1, 12);
    end
    out_stall_i <= (stall_run != 0);
  end

  // ---------------------------------------------------------------------------
  // Directed table. Only the opening rows carry a typed result: first beat
  // from reset (stride index + 1), a repeat hit, and a return to zero.
  // ---------------------------------------------------------------------------
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b0, REG_NONE, 16'h0, 31'h7FFF_FFFF, 1'b1, '{1'b0, 32'd0, 32'd1, 32'h8000_0000}},
    '{1'b0, REG_NONE, 16'h0, 31'h7FFF_FFFF, 1'b1, '{1'b1, 32'd1, 32'd2, 32'h8000_0000}},
    '{1'b0, REG_NONE, 16'h0, 31'd0,         1'b1, '{1'b0, 32'd1, 32'd3, 32'h8000_0000}},
    // fill set 0, hit to refresh block 0, then two evictions under LRU
    '{1'b0, REG_NONE, 16'h0, 31'd64,  1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd128, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd192, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd0,   1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd256, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd64,  1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd0,   1'b0, '0},
    // FIFO: a hit leaves the order, so the first block in is still evicted
    '{1'b1, REG_LRU_MODE, 16'h0000, 31'd0, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd1,   1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd65,  1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd129, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd193, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd1,   1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd257, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd1,   1'b0, '0},
    // zero granule divides by one
    '{1'b1, REG_GRANULE, 16'h0000, 31'd0, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd5,   1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd5,   1'b0, '0},
    // largest granule
    '{1'b1, REG_GRANULE, 16'hFFFF, 31'd0, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'h7FFF_FFFF, 1'b0, '0},
    '{1'b0, REG_NONE, 16'h0, 31'd65534,     1'b0, '0},
    // write to an unmapped index is dropped; lru_mode takes bit 0 only
    '{1'b1, REG_NONE,     16'h0002, 31'd0, 1'b0, '0},
    '{1'b1, REG_LRU_MODE, 16'hFFFF, 31'd0, 1'b0, '0},
    '{1'b1, REG_GRANULE,  16'h0001, 31'd0, 1'b0, '0}
  };

  // random phases: granule and replacement policy per phase
  logic [GRAN_W-1:0] phase_gran [PHASES] =
    '{16'd1, 16'd4, 16'hFFFF, 16'd0, 16'd7, 16'd1, 16'd300};
  bit                phase_lru  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  bit          feeding   = 1'b0;  // in_valid_i left high after the last beat
  bit          cfg_open  = 1'b0;  // cfg_valid_i left high after the last write
  bit          no_gaps   = 1'b0;  // stretch of back-to-back beats
  int unsigned burst_left = 0;
  int unsigned block_pool [POOL_LEN];

  task automatic drive_beat(logic [IDX_W-1:0] idx, bit typed, cache_result_t want);
    cache_result_t r;
    in_valid_i      <= 1'b1;
    element_index_i <= idx;
    feeding = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = cache_access(idx);
    result_q.push_back(typed ? want : r);
  endtask

  task automatic drop_valid();
    if (feeding) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
    end
  endtask

  // bursts of random length with random gaps in between
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        drop_valid();
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic close_cfg();
    if (cfg_open) begin
      cfg_valid_i <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  // registers only change with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drop_valid();
    while (result_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_open = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GRANULE:  granule_q = data[GRAN_W-1:0];
      REG_LRU_MODE: lru_q = data[0];
      default: ;
    endcase
  endtask

  initial begin
    int unsigned      divisor;
    int unsigned      junk;
    logic [IDX_W-1:0] idx;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        close_cfg();
        pace();
        drive_beat(plan[i].index, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      junk = $urandom();
      write_reg(REG_GRANULE, phase_gran[p]);
      write_reg(REG_LRU_MODE, {junk[CFG_DATA_W-1:1], phase_lru[p]});
      close_cfg();
      no_gaps = ($urandom_range(0, 3) == 0);
      divisor = (phase_gran[p] == '0) ? 1 : phase_gran[p];
      // working set over two sets, more blocks than ways so evictions happen
      for (int b = 0; b < POOL_LEN; b++) begin
        if (b == 0 || b == POOL_LEN / 2) junk = $urandom_range(0, SETS - 1);
        block_pool[b] = junk + SETS * $urandom_range(0, 7);
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          idx = IDX_W'(block_pool[$urandom_range(0, POOL_LEN - 1)] * divisor
                       + $urandom_range(0, divisor - 1));
        end else begin
          junk = $urandom();
          idx  = junk[IDX_W-1:0];
        end
        pace();
        drive_beat(idx, 1'b0, '0);
      end
    end

    drop_valid();
    while (result_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
